// ===== rtl/metm_pkg.sv =====
// Shared types and constants for the MIDI event encoder with tempo map.
// Used by metm_ctrl, metm_datapath and the top level; depends on nothing.
package metm_pkg;

	typedef enum logic [2:0] {
		OP_HEADER        = 3'd0,
		OP_TEMPO         = 3'd1,
		OP_NOTE          = 3'd2,
		OP_KEY_PRESSURE  = 3'd3,
		OP_CONTROL       = 3'd4,
		OP_PROGRAM       = 3'd5,
		OP_CHAN_PRESSURE = 3'd6,
		OP_PITCH_BEND    = 3'd7
	} op_t;

	// status nibbles of the channel messages
	localparam logic [3:0] ST_NOTE_OFF      = 4'h8;
	localparam logic [3:0] ST_NOTE_ON       = 4'h9;
	localparam logic [3:0] ST_KEY_PRESSURE  = 4'hA;
	localparam logic [3:0] ST_CONTROL       = 4'hB;
	localparam logic [3:0] ST_PROGRAM       = 4'hC;
	localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;
	localparam logic [3:0] ST_PITCH_BEND    = 4'hE;

	localparam logic [1:0] COUNT_SHORT = 2'd2;
	localparam logic [1:0] COUNT_LONG  = 2'd3;

	localparam int SAMPLE_RATE_W = 18;
	localparam int TPQ_W         = 15;
	localparam int TEMPO_W       = 24;
	localparam int FRAC_BITS     = 32;
	localparam int NUM_W         = SAMPLE_RATE_W + TEMPO_W;   // 42
	localparam int DEN_W         = 35;                        // 1e6 * (2^15-1) < 2^35
	localparam int DVD_W         = NUM_W + FRAC_BITS;         // 74
	localparam int DIV_STEPS     = DVD_W;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RESET = 18'd48000;
	localparam logic [TEMPO_W-1:0]       TEMPO_RESET       = 24'd500000;
	localparam logic [31:0]              US_PER_SEC        = 32'd1000000;
	localparam logic [13:0]              BEND_CENTER       = 14'h2000;

	typedef struct packed {
		logic load_item;
		logic frame_lo;
		logic frame_hi;
		logic seg_update;
		logic emit;
		logic note_off;
		logic mul_num;
		logic mul_den;
		logic div_step;
		logic rate_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic out_free;
		logic div_last;
	} dp_status_t;

endpackage

// ===== rtl/metm_ctrl.sv =====
// Controller state machine of the MIDI event encoder.
// Sequences frame stamping, message output and the tempo-map divide; uses metm_pkg.
module metm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  metm_pkg::op_t          in_op,
	output logic                   in_ready,
	input  metm_pkg::dp_status_t   status,
	output metm_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_FR_LO   = 9'b000000010,
		S_FR_HI   = 9'b000000100,
		S_SEG     = 9'b000001000,
		S_EMIT    = 9'b000010000,
		S_MUL_NUM = 9'b000100000,
		S_MUL_DEN = 9'b001000000,
		S_DIV     = 9'b010000000,
		S_LOAD    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.note_off = phase_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
				if (in_valid) begin
					phase_d = 1'b0;
					state_d = (in_op == metm_pkg::OP_HEADER) ? S_MUL_NUM : S_FR_LO;
				end
			end
			S_FR_LO: begin
				cmd.frame_lo = 1'b1;
				state_d      = S_FR_HI;
			end
			S_FR_HI: begin
				cmd.frame_hi = 1'b1;
				state_d      = (status.op == metm_pkg::OP_TEMPO) ? S_SEG : S_EMIT;
			end
			S_SEG: begin
				cmd.seg_update = 1'b1;
				state_d        = S_MUL_NUM;
			end
			S_EMIT: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.op == metm_pkg::OP_NOTE && !phase_q) begin
						phase_d = 1'b1;
						state_d = S_FR_LO;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_MUL_NUM: begin
				cmd.mul_num = 1'b1;
				state_d     = S_MUL_DEN;
			end
			S_MUL_DEN: begin
				cmd.mul_den = 1'b1;
				state_d     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.rate_load = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ===== rtl/metm_datapath.sv =====
// Datapath of the MIDI event encoder: tempo-map state, shared 32x32 multiplier,
// restoring divider for samples per tick, and the output register; uses metm_pkg.
module metm_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  metm_pkg::ctrl_cmd_t                   cmd,
	output metm_pkg::dp_status_t                  status,
	input  logic                                  cfg_wr_en,
	input  logic [metm_pkg::SAMPLE_RATE_W-1:0]    cfg_wr_data,
	input  logic [2:0]                            opcode,
	input  logic [31:0]                           tick,
	input  logic [3:0]                            channel,
	input  logic [6:0]                            first_data,
	input  logic [6:0]                            second_data,
	input  logic [6:0]                            release_velocity,
	input  logic [31:0]                           note_length,
	input  logic [23:0]                           setting_value,
	input  logic signed [13:0]                    bend,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [31:0]                           frame_time,
	output logic [7:0]                            status_byte,
	output logic [6:0]                            first_byte,
	output logic [6:0]                            second_byte,
	output logic [1:0]                            byte_count,
	output logic                                  last_of_run
);

	// tempo-map state
	logic [metm_pkg::SAMPLE_RATE_W-1:0] sample_rate_q;
	logic [metm_pkg::TPQ_W-1:0]         tpq_q;
	logic [metm_pkg::TEMPO_W-1:0]       tempo_q;
	logic [63:0]                        spt_q;
	logic [31:0]                        seg_frame_q;
	logic [31:0]                        seg_tick_q;

	// held item
	metm_pkg::op_t op_q;
	logic [31:0]   tick_q;
	logic [3:0]    ch_q;
	logic [6:0]    d1_q;
	logic [6:0]    d2_q;
	logic [6:0]    rv_q;
	logic [31:0]   len_q;
	logic [13:0]   bend_q;
	logic [31:0]   time_q;
	logic [31:0]   acc_q;

	// divider
	logic [metm_pkg::DVD_W-1:0]     dvd_q;
	logic [metm_pkg::DEN_W-1:0]     den_q;
	logic [metm_pkg::DEN_W-1:0]     rem_q;
	logic [63:0]                    quo_q;
	logic [metm_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [metm_pkg::DEN_W:0]       rem_shift;
	logic [metm_pkg::DEN_W:0]       rem_sub;
	logic                           rem_ge;

	logic [31:0] mul_a, mul_b, delta;
	logic [63:0] prod;

	logic [7:0]  msg_status;
	logic [6:0]  msg_b1, msg_b2;
	logic [1:0]  msg_count;
	logic        msg_last;
	logic [13:0] bend_val;

	assign delta = time_q - seg_tick_q;

	always_comb begin
		priority if (cmd.frame_lo) begin
			mul_a = spt_q[31:0];
			mul_b = delta;
		end else if (cmd.frame_hi) begin
			mul_a = spt_q[63:32];
			mul_b = delta;
		end else if (cmd.mul_num) begin
			mul_a = {{(32 - metm_pkg::TEMPO_W){1'b0}}, tempo_q};
			mul_b = {{(32 - metm_pkg::SAMPLE_RATE_W){1'b0}}, sample_rate_q};
		end else begin
			mul_a = {{(32 - metm_pkg::TPQ_W){1'b0}}, tpq_q};
			mul_b = metm_pkg::US_PER_SEC;
		end
	end

	assign prod = mul_a * mul_b;

	assign rem_shift = {rem_q, dvd_q[metm_pkg::DVD_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, den_q});
	assign rem_sub   = rem_shift - {1'b0, den_q};

	assign status.op       = op_q;
	assign status.out_free = !out_valid || out_ready;
	assign status.div_last = (div_cnt_q == metm_pkg::DIV_CNT_W'(metm_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= metm_pkg::SAMPLE_RATE_RESET;
			tpq_q         <= '0;
			tempo_q       <= metm_pkg::TEMPO_RESET;
			spt_q         <= '0;
			seg_frame_q   <= '0;
			seg_tick_q    <= '0;
			div_cnt_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				sample_rate_q <= cfg_wr_data;
			end
			if (cmd.load_item) begin
				if (metm_pkg::op_t'(opcode) == metm_pkg::OP_HEADER) begin
					tpq_q <= setting_value[metm_pkg::TPQ_W-1:0];
				end
				if (metm_pkg::op_t'(opcode) == metm_pkg::OP_TEMPO) begin
					tempo_q <= setting_value;
				end
			end
			if (cmd.seg_update) begin
				seg_frame_q <= acc_q;
				seg_tick_q  <= tick_q;
			end
			if (cmd.mul_num) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			// no header yet means zero divisor: samples per tick stays zero
			if (cmd.rate_load) begin
				spt_q <= (tpq_q == '0) ? 64'd0 : quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= metm_pkg::op_t'(opcode);
			tick_q <= tick;
			ch_q   <= channel;
			d1_q   <= first_data;
			d2_q   <= second_data;
			rv_q   <= release_velocity;
			len_q  <= note_length;
			bend_q <= $unsigned(bend);
			time_q <= tick;
		end else if (cmd.emit && op_q == metm_pkg::OP_NOTE && !cmd.note_off) begin
			// advance to the note-off tick
			time_q <= tick_q + len_q;
		end
		if (cmd.frame_lo) begin
			acc_q <= seg_frame_q + prod[63:32];
		end else if (cmd.frame_hi) begin
			acc_q <= acc_q + prod[31:0];
		end
		if (cmd.mul_num) begin
			dvd_q <= {prod[metm_pkg::NUM_W-1:0], {metm_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[metm_pkg::DVD_W-2:0], 1'b0};
			rem_q <= rem_ge ? rem_sub[metm_pkg::DEN_W-1:0] : rem_shift[metm_pkg::DEN_W-1:0];
			quo_q <= {quo_q[62:0], rem_ge};
		end
		if (cmd.mul_den) begin
			den_q <= prod[metm_pkg::DEN_W-1:0];
		end
	end

	assign bend_val = bend_q + metm_pkg::BEND_CENTER;

	always_comb begin
		msg_b1    = d1_q;
		msg_b2    = d2_q;
		msg_count = metm_pkg::COUNT_LONG;
		msg_last  = 1'b1;
		unique case (op_q)
			metm_pkg::OP_NOTE: begin
				if (cmd.note_off) begin
					msg_status = {metm_pkg::ST_NOTE_OFF, ch_q};
					msg_b2     = rv_q;
				end else begin
					msg_status = {metm_pkg::ST_NOTE_ON, ch_q};
					msg_last   = 1'b0;
				end
			end
			metm_pkg::OP_KEY_PRESSURE: msg_status = {metm_pkg::ST_KEY_PRESSURE, ch_q};
			metm_pkg::OP_CONTROL:      msg_status = {metm_pkg::ST_CONTROL, ch_q};
			metm_pkg::OP_PROGRAM: begin
				msg_status = {metm_pkg::ST_PROGRAM, ch_q};
				msg_b2     = '0;
				msg_count  = metm_pkg::COUNT_SHORT;
			end
			metm_pkg::OP_CHAN_PRESSURE: begin
				msg_status = {metm_pkg::ST_CHAN_PRESSURE, ch_q};
				msg_b2     = '0;
				msg_count  = metm_pkg::COUNT_SHORT;
			end
			metm_pkg::OP_PITCH_BEND: begin
				msg_status = {metm_pkg::ST_PITCH_BEND, ch_q};
				msg_b1     = bend_val[6:0];
				msg_b2     = bend_val[13:7];
			end
			default: begin
				// header and tempo never reach the output
				msg_status = {metm_pkg::ST_CONTROL, ch_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			frame_time  <= acc_q;
			status_byte <= msg_status;
			first_byte  <= msg_b1;
			second_byte <= msg_b2;
			byte_count  <= msg_count;
			last_of_run <= msg_last;
		end
	end

endmodule

// ===== rtl/midi_event_encoder_with_tempo_map_top.sv =====
// MIDI event encoder with tempo map: channel messages stamped with sample frames.
// Channel events: each accepted item gives one stamped output word, a note also its
// note-off word. The frame stamp takes two passes of the shared 32x32 multiplier.
// Header and tempo items rerun the one-bit-per-cycle 74-step divider; one item is
// in progress at a time. Reset (arst_n low) restores sample rate 48000, tempo
// 500000 us, zero ticks per quarter, samples per tick and segment start.
module midi_event_encoder_with_tempo_map_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [metm_pkg::SAMPLE_RATE_W-1:0]  cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          opcode,
	input  logic [31:0]                         tick,
	input  logic [3:0]                          channel,
	input  logic [6:0]                          first_data,
	input  logic [6:0]                          second_data,
	input  logic [6:0]                          release_velocity,
	input  logic [31:0]                         note_length,
	input  logic [23:0]                         setting_value,
	input  logic signed [13:0]                  bend,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         frame_time,
	output logic [7:0]                          status_byte,
	output logic [6:0]                          first_byte,
	output logic [6:0]                          second_byte,
	output logic [1:0]                          byte_count,
	output logic                                last_of_run
);

	metm_pkg::ctrl_cmd_t  cmd;
	metm_pkg::dp_status_t status;

	metm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (metm_pkg::op_t'(opcode)),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	metm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.opcode           (opcode),
		.tick             (tick),
		.channel          (channel),
		.first_data       (first_data),
		.second_data      (second_data),
		.release_velocity (release_velocity),
		.note_length      (note_length),
		.setting_value    (setting_value),
		.bend             (bend),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.frame_time       (frame_time),
		.status_byte      (status_byte),
		.first_byte       (first_byte),
		.second_byte      (second_byte),
		.byte_count       (byte_count),
		.last_of_run      (last_of_run)
	);

endmodule
